### rtl/pra_pkg.sv
// Shared types and constants for the page range extent allocator.
// Holds the extent entry layout, command codes and status codes; no dependencies.
`default_nettype none

package pra_pkg;

    // Fixed geometry of the managed region
    localparam int PAGE_BITS = 12;
    localparam int ADDR_BITS = 48;
    localparam int SIZE_W    = 49;
    localparam int PN_W      = ADDR_BITS - PAGE_BITS;  // page number
    localparam int LEN_W     = PN_W + 1;               // length in pages
    localparam int PG_W      = SIZE_W - PAGE_BITS + 1; // rounded request in pages

    // Command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RESERVE = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOFIT      = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_BUSY       = 3'd3,
        ST_OVERRUN    = 3'd4,
        ST_NOTFOUND   = 3'd5,
        ST_FULL       = 3'd6,
        ST_INVALID    = 3'd7
    } t_status;

    // One extent table entry
    typedef struct packed {
        logic [PN_W-1:0]  start;
        logic [LEN_W-1:0] len;
        logic             free;
    } t_ent;

endpackage

`default_nettype wire

### rtl/pra_mem.sv
// Extent table storage: one write port, one read port, registered read data.
// Depends on pra_pkg for the entry layout.
`default_nettype none

module pra_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire pra_pkg::t_ent   i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output pra_pkg::t_ent        o_rdata
);

    pra_pkg::t_ent mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/page_range_extent_allocator.sv
// Top level of the page range extent allocator: command sequencer over the extent table.
// Depends on pra_pkg and pra_mem.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  command  | i_valid / o_ready  | i_cmd, i_size_bytes, i_address
//  result   | o_valid / i_ready  | o_status, o_result_address
//
// Each command scans the table one entry per cycle (one read of the table memory),
// then moves later entries up or down, one read and one write per entry, then writes
// up to three entries.
// After reset the sequencer writes the initial free extent before the first command is taken.
// A command is taken while an earlier result still waits; the sequencer holds at the
// end only if that result is still not taken.
`default_nettype none

module page_range_extent_allocator #(
    parameter int MAX_EXTENTS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [pra_pkg::SIZE_W-1:0]    i_size_bytes,
    input  wire logic [pra_pkg::ADDR_BITS-1:0] i_address,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_status,
    output logic [pra_pkg::ADDR_BITS-1:0]      o_result_address
);

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int PN_W  = pra_pkg::PN_W;
    localparam int LEN_W = pra_pkg::LEN_W;
    localparam int PG_W  = pra_pkg::PG_W;
    localparam int PB    = pra_pkg::PAGE_BITS;
    localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_EV    = 9'b000001000,
        S_NX    = 9'b000010000,
        S_MV_RD = 9'b000100000,
        S_MV_WR = 9'b001000000,
        S_WR    = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_cnt_nx, n_cnt_nx;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_i, n_i;
    logic [1:0]          r_d, n_d;
    logic                r_up, n_up;
    logic [1:0]          r_cmd, n_cmd;
    logic [PG_W-1:0]     r_pages, n_pages;
    logic [PN_W-1:0]     r_vpage, n_vpage;
    pra_pkg::t_ent       r_ent, n_ent;
    pra_pkg::t_ent       r_prev, n_prev;
    logic [IW-1:0]       r_wa [3];
    logic [IW-1:0]       n_wa [3];
    pra_pkg::t_ent       r_wd [3];
    pra_pkg::t_ent       n_wd [3];
    logic [1:0]          r_wn, n_wn;
    logic [1:0]          r_wi, n_wi;
    pra_pkg::t_status    r_status, n_status;
    logic [PN_W-1:0]     r_rpage, n_rpage;
    logic                r_o_valid, n_o_valid;
    logic [2:0]          r_o_status, n_o_status;
    logic [pra_pkg::ADDR_BITS-1:0] r_o_addr, n_o_addr;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    pra_pkg::t_ent       mem_wdata;
    logic [IW-1:0]       mem_raddr;
    pra_pkg::t_ent       mem_rdata;

    pra_mem #(
        .DEPTH (MAX_EXTENTS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Command decode helpers
    logic [PB+PG_W-1:0]  size_rnd;
    logic [PG_W-1:0]     in_pages;
    logic                in_misal;

    assign size_rnd = {1'b0, i_size_bytes} + (PB+PG_W)'({PB{1'b1}});
    assign in_pages = size_rnd[PB+PG_W-1:PB];
    assign in_misal = |i_address[PB-1:0];

    // Scan and split helpers
    logic [CW-1:0]       k_inc;
    logic [LEN_W-1:0]    e_end;
    logic [PG_W:0]       rend;
    logic                hit;
    logic                head, tail;
    logic [1:0]          need;
    logic [CW:0]         cnt_need;
    logic                nf, pf;
    logic [LEN_W-1:0]    rel_len;
    logic [CW-1:0]       i_inc;

    assign k_inc = r_k + 1'b1;
    assign i_inc = r_i + 1'b1;
    assign e_end = LEN_W'(mem_rdata.start) + mem_rdata.len;
    assign rend  = (PG_W+1)'(r_vpage) + (PG_W+1)'(r_pages);
    assign head  = r_vpage > mem_rdata.start;
    assign tail  = rend < (PG_W+1)'(e_end);
    assign need  = 2'(head) + 2'(tail);
    assign cnt_need = (CW+1)'(r_count) + (CW+1)'(need);
    assign nf = (i_inc < r_count) && mem_rdata.free;
    assign pf = (r_i != '0) && r_prev.free;
    assign rel_len = r_ent.len + (nf ? mem_rdata.len : '0) + (pf ? r_prev.len : '0);

    always_comb begin
        case (r_cmd)
            pra_pkg::CMD_ALLOC:   hit = mem_rdata.free &&
                                        (PG_W'(mem_rdata.len) >= r_pages);
            pra_pkg::CMD_RESERVE: hit = (r_vpage >= mem_rdata.start) &&
                                        (LEN_W'(r_vpage) < e_end);
            default:              hit = (mem_rdata.start == r_vpage);
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cnt_nx  = r_cnt_nx;
        n_k       = r_k;
        n_lo      = r_lo;
        n_i       = r_i;
        n_d       = r_d;
        n_up      = r_up;
        n_cmd     = r_cmd;
        n_pages   = r_pages;
        n_vpage   = r_vpage;
        n_ent     = r_ent;
        n_prev    = r_prev;
        n_wa      = r_wa;
        n_wd      = r_wd;
        n_wn      = r_wn;
        n_wi      = r_wi;
        n_status  = r_status;
        n_rpage   = r_rpage;
        n_o_valid = r_o_valid;
        n_o_status = r_o_status;
        n_o_addr  = r_o_addr;
        mem_we    = 1'b0;
        mem_waddr = r_k[IW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_k[IW-1:0];
        o_ready   = (r_state == S_IDLE);

        // Drop the result once taken
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            // Write the single free extent covering the region
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{start: '0, len: LEN_W'(1) << PN_W, free: 1'b1};
                n_count   = CW'(1);
                n_state   = S_IDLE;
            end
            // Take a transaction and reject the trivial cases at once
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_pages = in_pages;
                    n_vpage = i_address[pra_pkg::ADDR_BITS-1:PB];
                    n_rpage = '0;
                    n_k     = '0;
                    n_state = S_DONE;
                    unique case (i_cmd)
                        pra_pkg::CMD_ALLOC: begin
                            if (in_pages == '0) n_status = pra_pkg::ST_INVALID;
                            else n_state = S_RD;
                        end
                        pra_pkg::CMD_RESERVE: begin
                            if (in_misal) n_status = pra_pkg::ST_MISALIGNED;
                            else if (in_pages == '0) n_status = pra_pkg::ST_INVALID;
                            else n_state = S_RD;
                        end
                        pra_pkg::CMD_RELEASE: begin
                            if (in_misal) n_status = pra_pkg::ST_NOTFOUND;
                            else n_state = S_RD;
                        end
                        default: n_status = pra_pkg::ST_INVALID;
                    endcase
                end
            end
            // Issue the first scan read
            S_RD: begin
                mem_raddr = r_k[IW-1:0];
                n_state   = S_EV;
            end
            // Check one entry per cycle, reading the next one ahead
            S_EV: begin
                mem_raddr = k_inc[IW-1:0];
                if (!hit) begin
                    n_prev = mem_rdata;
                    n_k    = k_inc;
                    if (k_inc == r_count) begin
                        if (r_cmd == pra_pkg::CMD_ALLOC) n_status = pra_pkg::ST_NOFIT;
                        else n_status = pra_pkg::ST_NOTFOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_i   = r_k;
                    n_ent = mem_rdata;
                    n_lo  = k_inc;
                    n_up  = 1'b1;
                    n_k   = r_count - 1'b1;
                    n_wi  = '0;
                    unique case (r_cmd)
                        pra_pkg::CMD_ALLOC: begin
                            n_rpage = mem_rdata.start;
                            if (PG_W'(mem_rdata.len) == r_pages) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_k[IW-1:0];
                                mem_wdata = '{start: mem_rdata.start,
                                              len: mem_rdata.len, free: 1'b0};
                                n_status  = pra_pkg::ST_OK;
                                n_state   = S_DONE;
                            end else if (r_count >= MAXC) begin
                                n_status = pra_pkg::ST_FULL;
                                n_rpage  = '0;
                                n_state  = S_DONE;
                            end else begin
                                n_d      = 2'd1;
                                n_cnt_nx = k_inc == '0 ? r_count : r_count + 1'b1;
                                n_wn     = 2'd2;
                                n_wa[0]  = r_k[IW-1:0];
                                n_wd[0]  = '{start: mem_rdata.start,
                                             len: LEN_W'(r_pages), free: 1'b0};
                                n_wa[1]  = k_inc[IW-1:0];
                                n_wd[1]  = '{start: mem_rdata.start + PN_W'(r_pages),
                                             len: mem_rdata.len - LEN_W'(r_pages),
                                             free: 1'b1};
                                n_state  = (r_count > k_inc) ? S_MV_RD : S_WR;
                            end
                        end
                        pra_pkg::CMD_RESERVE: begin
                            n_rpage = r_vpage;
                            n_state = S_DONE;
                            if (!mem_rdata.free) begin
                                n_status = pra_pkg::ST_BUSY;
                                n_rpage  = '0;
                            end else if (rend > (PG_W+1)'(e_end)) begin
                                n_status = pra_pkg::ST_OVERRUN;
                                n_rpage  = '0;
                            end else if (cnt_need > (CW+1)'(MAX_EXTENTS)) begin
                                n_status = pra_pkg::ST_FULL;
                                n_rpage  = '0;
                            end else begin
                                n_d      = need;
                                n_cnt_nx = cnt_need[CW-1:0];
                                n_wn     = 2'd1 + need;
                                n_wa[0]  = r_k[IW-1:0];
                                n_wd[0]  = '{start: mem_rdata.start,
                                             len: LEN_W'(r_vpage - mem_rdata.start),
                                             free: 1'b1};
                                n_wa[1]  = k_inc[IW-1:0];
                                n_wd[1]  = '{start: r_vpage,
                                             len: LEN_W'(r_pages), free: 1'b0};
                                n_wa[2]  = IW'(k_inc + CW'(head));
                                n_wd[2]  = '{start: PN_W'(rend),
                                             len: LEN_W'((PG_W+1)'(e_end) - rend),
                                             free: 1'b1};
                                if (!head) begin
                                    n_wa[0] = r_k[IW-1:0];
                                    n_wd[0] = n_wd[1];
                                    n_wa[1] = n_wa[2];
                                    n_wd[1] = n_wd[2];
                                end
                                n_state = (need != '0 && r_count > k_inc) ? S_MV_RD
                                                                           : S_WR;
                            end
                        end
                        default: begin
                            n_state = S_NX;
                        end
                    endcase
                end
            end
            // Release: look at the following and previous entries and plan the merge
            S_NX: begin
                n_wn     = 2'd1;
                n_wa[0]  = pf ? IW'(r_i - 1'b1) : r_i[IW-1:0];
                n_wd[0]  = '{start: pf ? r_prev.start : r_ent.start,
                             len: rel_len, free: 1'b1};
                n_d      = 2'(nf) + 2'(pf);
                n_up     = 1'b0;
                n_lo     = i_inc + CW'(nf);
                n_k      = i_inc + CW'(nf);
                n_cnt_nx = r_count - CW'(2'(nf) + 2'(pf));
                n_status = pra_pkg::ST_OK;
                n_state  = ((nf || pf) && (i_inc + CW'(nf)) < r_count) ? S_MV_RD
                                                                        : S_WR;
            end
            // Move one entry: read it
            S_MV_RD: begin
                mem_raddr = r_k[IW-1:0];
                n_state   = S_MV_WR;
            end
            // Move one entry: write it at its new place and advance
            S_MV_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_waddr = r_up ? IW'(r_k + CW'(r_d)) : IW'(r_k - CW'(r_d));
                n_state   = S_MV_RD;
                if (r_up) begin
                    n_k = r_k - 1'b1;
                    if (r_k == r_lo) n_state = S_WR;
                end else begin
                    n_k = k_inc;
                    if (k_inc == r_count) n_state = S_WR;
                end
            end
            // Write the new extents
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_wa[r_wi];
                mem_wdata = r_wd[r_wi];
                n_wi      = r_wi + 1'b1;
                if (r_wi + 1'b1 == r_wn) begin
                    n_count  = r_cnt_nx;
                    n_status = pra_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            // Hand the result over once the output register is free
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_addr   = (r_status == pra_pkg::ST_OK)
                               ? {r_rpage, {PB{1'b0}}} : '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_count   <= CW'(1);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_cnt_nx   <= n_cnt_nx;
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_i        <= n_i;
        r_d        <= n_d;
        r_up       <= n_up;
        r_cmd      <= n_cmd;
        r_pages    <= n_pages;
        r_vpage    <= n_vpage;
        r_ent      <= n_ent;
        r_prev     <= n_prev;
        r_wa       <= n_wa;
        r_wd       <= n_wd;
        r_wn       <= n_wn;
        r_wi       <= n_wi;
        r_status   <= n_status;
        r_rpage    <= n_rpage;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_result_address = r_o_addr;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_count >= CW'(1) && r_count <= MAXC))
        else $error("extent count out of range");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != pra_pkg::ST_OK) |-> (o_result_address == '0))
        else $error("failed transaction with non-zero address");

    a_write_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_wn != 2'd0 && r_wi < r_wn))
        else $error("write index beyond planned writes");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// Testbench for the page range extent allocator: directed and random commands with a
// scoreboard that mirrors the extent table. Depends on pra_pkg and the top level RTL.
`timescale 1ns / 100ps

import pra_pkg::*;

class extent_scoreboard;
    localparam int DEPTH = 64;
    logic [PN_W-1:0]  ent_start [DEPTH];
    logic [LEN_W-1:0] ent_len   [DEPTH];
    bit               ent_free  [DEPTH];
    int               ent_count;
    t_status             want_status [$];
    logic [ADDR_BITS-1:0] want_addr  [$];
    int                  fail_count;

    function new();
        for (int k = 0; k < DEPTH; k++) begin
            ent_start[k] = '0; ent_len[k] = '0; ent_free[k] = 0;
        end
        ent_len[0] = LEN_W'(1) << PN_W;
        ent_free[0] = 1;
        ent_count = 1;
        fail_count = 0;
    endfunction

    // Shift later entries up to make room at pos
    function void open_slot(int pos);
        for (int k = ent_count; k > pos; k--) begin
            ent_start[k] = ent_start[k-1]; ent_len[k] = ent_len[k-1];
            ent_free[k] = ent_free[k-1];
        end
        ent_count++;
    endfunction

    // Shift later entries down over pos
    function void close_slot(int pos);
        for (int k = pos; k + 1 < ent_count; k++) begin
            ent_start[k] = ent_start[k+1]; ent_len[k] = ent_len[k+1];
            ent_free[k] = ent_free[k+1];
        end
        ent_count--;
    endfunction

    function t_status allocate(logic [LEN_W:0] pages, output logic [ADDR_BITS-1:0] a);
        int i;
        a = '0;
        for (i = 0; i < ent_count; i++)
            if (ent_free[i] && {1'b0, ent_len[i]} >= pages) break;
        if (i >= ent_count) return ST_NOFIT;
        if ({1'b0, ent_len[i]} != pages) begin
            if (ent_count >= DEPTH) return ST_FULL;
            open_slot(i + 1);
            ent_start[i+1] = ent_start[i] + PN_W'(pages);
            ent_len[i+1] = ent_len[i] - LEN_W'(pages);
            ent_free[i+1] = 1;
            ent_len[i] = LEN_W'(pages);
        end
        ent_free[i] = 0;
        a = {ent_start[i], {PAGE_BITS{1'b0}}};
        return ST_OK;
    endfunction

    function t_status reserve(logic [PN_W-1:0] vp, logic [LEN_W:0] pages,
                              output logic [ADDR_BITS-1:0] a);
        int i, need;
        logic [LEN_W+1:0] st, en, re;
        a = '0;
        for (i = 0; i < ent_count; i++)
            if (vp >= ent_start[i] && vp < ent_start[i] + ent_len[i]) break;
        if (i >= ent_count) return ST_NOTFOUND;
        if (!ent_free[i]) return ST_BUSY;
        st = ent_start[i];
        en = st + ent_len[i];
        re = vp + pages;
        if (re > en) return ST_OVERRUN;
        need = (vp > st) + (re < en);
        if (ent_count + need > DEPTH) return ST_FULL;
        if (re < en) begin
            open_slot(i + 1);
            ent_start[i+1] = PN_W'(re); ent_len[i+1] = LEN_W'(en - re); ent_free[i+1] = 1;
        end
        if (vp > st) begin
            open_slot(i);
            ent_start[i] = PN_W'(st); ent_len[i] = LEN_W'(vp - st); ent_free[i] = 1;
            i++;
        end
        ent_start[i] = vp; ent_len[i] = LEN_W'(pages); ent_free[i] = 0;
        a = {vp, {PAGE_BITS{1'b0}}};
        return ST_OK;
    endfunction

    function t_status release_at(logic [ADDR_BITS-1:0] ad);
        int i;
        if (ad[PAGE_BITS-1:0] != 0) return ST_NOTFOUND;
        for (i = 0; i < ent_count; i++)
            if (ent_start[i] == ad[ADDR_BITS-1:PAGE_BITS]) break;
        if (i >= ent_count) return ST_NOTFOUND;
        if (i + 1 < ent_count && ent_free[i+1]) begin
            ent_len[i] += ent_len[i+1];
            close_slot(i + 1);
        end
        if (i > 0 && ent_free[i-1]) begin
            ent_len[i-1] += ent_len[i];
            close_slot(i);
            i--;
        end
        ent_free[i] = 1;
        return ST_OK;
    endfunction

    // Note an accepted command transaction and queue its expected result
    function void note_command(logic [1:0] c, logic [SIZE_W-1:0] sz, logic [ADDR_BITS-1:0] ad);
        logic [SIZE_W:0] rounded;
        logic [LEN_W:0] pages;
        logic [ADDR_BITS-1:0] a;
        t_status s;
        rounded = {1'b0, sz} + ((1 << PAGE_BITS) - 1);
        pages = rounded[SIZE_W:PAGE_BITS];
        a = '0;
        case (c)
            CMD_ALLOC:   s = (pages == 0) ? ST_INVALID : allocate(pages, a);
            CMD_RESERVE: begin
                if (ad[PAGE_BITS-1:0] != 0) s = ST_MISALIGNED;
                else if (pages == 0) s = ST_INVALID;
                else s = reserve(ad[ADDR_BITS-1:PAGE_BITS], pages, a);
            end
            CMD_RELEASE: s = release_at(ad);
            default:     s = ST_INVALID;
        endcase
        if (s != ST_OK) a = '0;
        want_status.push_back(s);
        want_addr.push_back(a);
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [2:0] s, logic [ADDR_BITS-1:0] a);
        t_status es;
        logic [ADDR_BITS-1:0] ea;
        if (want_status.size() == 0) begin
            $error("unexpected result: status %0d address %h", s, a);
            fail_count++;
            return;
        end
        es = want_status.pop_front();
        ea = want_addr.pop_front();
        if (s !== es) begin
            $error("status: expected %0d, actual %0d", es, s);
            fail_count++;
        end
        if (a !== ea) begin
            $error("result_address: expected %h, actual %h", ea, a);
            fail_count++;
        end
    endfunction

    function int pending();
        return want_status.size();
    endfunction
endclass

module tb;
    localparam longint LIMIT = 2000000;

    logic                  i_clk, i_rst_n, i_valid, i_ready;
    logic [1:0]            i_cmd;
    logic [SIZE_W-1:0]     i_size_bytes;
    logic [ADDR_BITS-1:0]  i_address;
    logic                  o_ready, o_valid;
    logic [2:0]            o_status;
    logic [ADDR_BITS-1:0]  o_result_address;

    extent_scoreboard board;
    longint cycles;
    bit     sending_done;
    logic [ADDR_BITS-1:0] handed_out [$];

    page_range_extent_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_size_bytes(i_size_bytes), .i_address(i_address),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_result_address(o_result_address)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Record scoreboard activity and track addresses that came back
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_command(i_cmd, i_size_bytes, i_address);
            if (o_valid && i_ready) begin
                board.check_result(o_status, o_result_address);
                if (o_status == ST_OK && o_result_address != 0)
                    handed_out.push_back(o_result_address);
            end
        end
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side stalls at random
    initial begin
        i_ready = 0;
        @(posedge i_clk);
        forever begin
            repeat (gap_len()) begin
                i_ready <= 0;
                @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk);
        end
    end

    // Present one transaction and return at its accepting edge with valid still high
    task automatic send(logic [1:0] c, logic [SIZE_W-1:0] sz, logic [ADDR_BITS-1:0] ad);
        i_valid <= 1; i_cmd <= c; i_size_bytes <= sz; i_address <= ad;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_gapped(logic [1:0] c, logic [SIZE_W-1:0] sz,
                               logic [ADDR_BITS-1:0] ad);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        send(c, sz, ad);
    endtask

    // Mostly small sizes, a few huge ones
    function automatic logic [SIZE_W-1:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 80) return SIZE_W'($urandom_range(1, 40000));
        if (r < 90) return SIZE_W'({$urandom, $urandom});
        return SIZE_W'({$urandom, $urandom} >> $urandom_range(0, 30));
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_aligned();
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 1)) a = a >> $urandom_range(0, 30);
        return {a[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    endfunction

    initial begin
        logic [ADDR_BITS-1:0] a;
        int r, idx;
        longint waited;
        board = new();
        i_rst_n = 0; i_valid = 0; i_cmd = CMD_ALLOC; i_size_bytes = '0; i_address = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, every command and the special cases
        send(CMD_ALLOC, '0, '0);                           // zero size
        send(2'd3, 49'h1234, 48'h5000);                    // unknown command
        send(CMD_ALLOC, {1'b1, 48'h0}, '0);                // whole region
        send(CMD_ALLOC, 49'd1, '0);                        // no fit
        send(CMD_RELEASE, '0, '0);
        send(CMD_RELEASE, '0, '0);                         // release of free extent
        send(CMD_RELEASE, '0, 48'h1001);                   // misaligned release
        send(CMD_RELEASE, '0, 48'h7000);                   // not found
        send(CMD_ALLOC, 49'd1, '0);
        send(CMD_ALLOC, 49'h1fff_ffff_ffff_f, '0);         // all ones size
        send(CMD_RESERVE, 49'h1000, 48'h0fff);             // misaligned reserve
        send(CMD_RESERVE, '0, 48'h10_0000);                // zero size reserve
        send(CMD_RESERVE, 49'h1000, '0);                   // busy
        send(CMD_RESERVE, 49'h3000, 48'h10_0000);          // head and tail split
        send(CMD_RESERVE, {1'b1, 48'h0}, 48'h20_0000);     // overrun
        send(CMD_RESERVE, 49'h1000, 48'hffff_ffff_f000);   // last page
        send(CMD_RELEASE, '0, 48'h10_0000);
        send(CMD_RELEASE, '0, 48'hffff_ffff_f000);
        send(CMD_ALLOC, 49'h1_ffff_ffff_ffff, '0);
        send(CMD_RELEASE, '0, 48'hffff_ffff_ffff);

        // Fill the table to its limit with small reserves
        for (int k = 0; k < 40; k++)
            send_gapped(CMD_RESERVE, 49'h1000, 48'h40_0000 + k * 48'h2000);

        // Random: mostly alloc and release of handed-out ranges
        for (int n = 0; n < 600; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_gapped(CMD_ALLOC, rand_size(), ADDR_BITS'({$urandom, $urandom}));
            end else if (r < 55) begin
                a = rand_aligned();
                if ($urandom_range(0, 9) == 0) a = ADDR_BITS'({$urandom, $urandom});
                send_gapped(CMD_RESERVE, rand_size(), a);
            end else if (r < 90 && handed_out.size() > 0) begin
                idx = $urandom_range(0, handed_out.size() - 1);
                a = handed_out[idx];
                handed_out.delete(idx);
                send_gapped(CMD_RELEASE, SIZE_W'({$urandom, $urandom}), a);
            end else if (r < 97) begin
                send_gapped(CMD_RELEASE, rand_size(),
                            $urandom_range(0, 1) ? rand_aligned()
                                                 : ADDR_BITS'({$urandom, $urandom}));
            end else begin
                send_gapped(2'($urandom_range(0, 3)), rand_size(),
                            ADDR_BITS'({$urandom, $urandom}));
            end
        end
        i_valid <= 0;

        // Drain, then allow for any trailing activity
        waited = 0;
        while (board.pending() > 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (400) @(posedge i_clk);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
